[src/equirect_to_cubemap_address_top_assert.svh]
// assertion macros for the equirect to cubemap address block
// used by equirect_to_cubemap_address_top.sv, no other dependencies
`ifndef EQUIRECT_TO_CUBEMAP_ADDRESS_TOP_ASSERT_SVH
`define EQUIRECT_TO_CUBEMAP_ADDRESS_TOP_ASSERT_SVH

// same-cycle implication
`define E2C_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define E2C_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/e2c_pkg.sv]
// shared constants, angle table and register indexes for the equirect to cubemap block
// no dependencies
`timescale 1ns / 1ps

package e2c_pkg;

  // field widths
  localparam int FACE_W      = 3;
  localparam int FCOORD_W    = 9;
  localparam int DIM_W       = 14;
  localparam int CH_W        = 3;
  localparam int SCOORD_W    = 13;
  localparam int SOFF_W      = 28;
  localparam int DOFF_W      = 20;
  localparam int REG_IDX_W   = 2;

  localparam int FACE_SIZE_DEF = 512;

  // fixed point
  localparam int ONE_Q16      = 65536;
  localparam int ANG_BITS     = 18;
  localparam int CORDIC_STEPS = 16;
  localparam int INV_GAIN     = 39797;
  localparam int CW           = 22;
  localparam int AW           = 20;
  localparam int DIR_W        = 19;

  // register limits and reset values
  localparam int DIM_MAX   = 8192;
  localparam int CH_MAX    = 4;
  localparam int WIDTH_RST  = 2048;
  localparam int HEIGHT_RST = 1024;
  localparam int CH_RST     = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_CHANNELS
  } reg_idx_t;

  // atan(2^-i) as fraction of a turn, 2^18 per turn
  localparam logic signed [AW-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    20'sd32768, 20'sd19344, 20'sd10221, 20'sd5188, 20'sd2604, 20'sd1303,
    20'sd652, 20'sd326, 20'sd163, 20'sd81, 20'sd41, 20'sd20, 20'sd10,
    20'sd5, 20'sd3, 20'sd1
  };

endpackage

[src/e2c_if.sv]
// valid/ready channel interfaces for the equirect to cubemap block
// depends on e2c_pkg
`timescale 1ns / 1ps

interface e2c_in_if;
  logic                         valid;
  logic                         ready;
  logic [e2c_pkg::FACE_W-1:0]   face;
  logic [e2c_pkg::FCOORD_W-1:0] col;
  logic [e2c_pkg::FCOORD_W-1:0] row;

  modport source (output valid, face, col, row, input ready);
  modport sink (input valid, face, col, row, output ready);
endinterface

interface e2c_out_if;
  logic                         valid;
  logic                         ready;
  logic [e2c_pkg::SCOORD_W-1:0] src_col;
  logic [e2c_pkg::SCOORD_W-1:0] src_row;
  logic [e2c_pkg::SOFF_W-1:0]   src_offset;
  logic [e2c_pkg::DOFF_W-1:0]   dst_offset;

  modport source (output valid, src_col, src_row, src_offset, dst_offset, input ready);
  modport sink (input valid, src_col, src_row, src_offset, dst_offset, output ready);
endinterface

[src/equirect_to_cubemap_address_top.sv]
// equirect to cubemap address generator, fully pipelined
// depends on e2c_pkg, e2c_if.sv and equirect_to_cubemap_address_top_assert.svh
`timescale 1ns / 1ps
//
// Usage
//   in_ch carries one cube face pixel (face, col, row) per transaction; out_ch
//   returns the equirectangular source column and row, the source element
//   offset and the destination element offset on the face.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets src_width,
//   src_height and channels; write it only while no transaction is in flight.
// Depth and throughput
//   a result passes through 41 register stages; one transaction is taken
//   every cycle while out_ch is not stalled. The depth comes from two unrolled
//   16-step CORDIC chains (longitude, then latitude), a prep register and one
//   register per step each, plus divide, projection and offset multiply stages.
// Reset
//   rst clears every stage valid bit and loads 2048, 1024 and 3 into the
//   registers; the pipeline is empty and ready right after.
// Back pressure
//   when out_ch is stalled with a result pending, the whole pipeline holds and
//   in_ch.ready drops; nothing is lost or repeated. Bubbles pass without stall.
//
module equirect_to_cubemap_address_top #(
  parameter int FACE_SIZE = e2c_pkg::FACE_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [e2c_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [e2c_pkg::DIM_W-1:0]     cfg_data,
  e2c_in_if.sink                        in_ch,
  e2c_out_if.source                     out_ch
);
  import e2c_pkg::*;

  // divide by FACE_SIZE-1 split into constant quotient, remainder and reciprocal
  localparam int    DIV     = FACE_SIZE - 1;
  localparam int    QD      = (2 ** 17) / DIV;
  localparam int    RD      = (2 ** 17) % DIV;
  localparam longint RECIP  = ((64'd1 << 32) - 64'd1) / DIV;
  localparam int    XW      = 21;
  localparam int    COL_LIM = (DIV < 2 ** FCOORD_W) ? DIV : 2 ** FCOORD_W - 1;
  localparam logic [FCOORD_W-1:0] COL_MAX = FCOORD_W'(COL_LIM);
  localparam logic signed [AW-1:0] QUARTER = AW'(2 ** (ANG_BITS - 2));
  localparam logic signed [AW-1:0] HALF    = AW'(2 ** (ANG_BITS - 1));
  localparam logic signed [DIR_W-1:0] ONE_D = DIR_W'(ONE_Q16);

  // configuration registers
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic [CH_W-1:0]  channels;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  logic [CH_W-1:0]  ch_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(WIDTH_RST);
      src_height <= DIM_W'(HEIGHT_RST);
      channels   <= CH_W'(CH_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_CHANNELS:   channels   <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp register values into their legal ranges
  always_comb begin
    w_eff  = (src_width == '0) ? DIM_W'(1)
           : (src_width > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : src_width;
    h_eff  = (src_height == '0) ? DIM_W'(1)
           : (src_height > DIM_W'(DIM_MAX)) ? DIM_W'(DIM_MAX) : src_height;
    ch_eff = (channels == '0) ? CH_W'(1)
           : (channels > CH_W'(CH_MAX)) ? CH_W'(CH_MAX) : channels;
  end

  // global advance: hold everything while a result waits on a stalled sink
  logic en;
  logic o_vld;
  assign en = !o_vld || out_ch.ready;
  assign in_ch.ready = en;

  // stage a: clamp position, remainder products, destination position
  logic                a_vld;
  logic [FACE_W-1:0]   a_face;
  logic [FCOORD_W-1:0] a_col, a_row;
  logic [XW-1:0]       a_xc, a_xr;
  logic [DOFF_W-1:0]   a_dpos;
  logic [FCOORD_W-1:0] in_col, in_row;

  assign in_col = (in_ch.col > COL_MAX) ? COL_MAX : in_ch.col;
  assign in_row = (in_ch.row > COL_MAX) ? COL_MAX : in_ch.row;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_face <= (in_ch.face > FACE_W'(5)) ? FACE_W'(5) : in_ch.face;
      a_col  <= in_col;
      a_row  <= in_row;
      a_xc   <= XW'(in_col) * XW'(RD);
      a_xr   <= XW'(in_row) * XW'(RD);
      a_dpos <= DOFF_W'(in_row) * DOFF_W'(FACE_SIZE) + DOFF_W'(in_col);
    end
  end

  // stage b: reciprocal estimate of the remainder quotient, destination offset
  logic                b_vld;
  logic [FACE_W-1:0]   b_face;
  logic [FCOORD_W-1:0] b_col, b_row;
  logic [XW-1:0]       b_xc, b_xr, b_qc, b_qr;
  logic [DOFF_W-1:0]   b_dst;
  logic [XW+31:0]      prod_c, prod_r;

  assign prod_c = (XW + 32)'(a_xc) * (XW + 32)'(RECIP);
  assign prod_r = (XW + 32)'(a_xr) * (XW + 32)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_face <= a_face;
      b_col  <= a_col;
      b_row  <= a_row;
      b_xc   <= a_xc;
      b_xr   <= a_xr;
      b_qc   <= prod_c[XW+31:32];
      b_qr   <= prod_r[XW+31:32];
      b_dst  <= DOFF_W'(a_dpos * DOFF_W'(ch_eff));
    end
  end

  // stage c: correct the estimate and form u, v in Q1.16
  logic                    c_vld;
  logic [FACE_W-1:0]       c_face;
  logic signed [DIR_W-1:0] c_u, c_v;
  logic [DOFF_W-1:0]       c_dst;
  logic [XW-1:0]           rem_c, rem_r, fq_c, fq_r;
  logic [DIR_W-1:0]        sum_c, sum_r;

  always_comb begin
    rem_c = b_xc - XW'(b_qc * XW'(DIV));
    rem_r = b_xr - XW'(b_qr * XW'(DIV));
    fq_c  = (rem_c >= XW'(DIV)) ? b_qc + XW'(1) : b_qc;
    fq_r  = (rem_r >= XW'(DIV)) ? b_qr + XW'(1) : b_qr;
    sum_c = DIR_W'(DIR_W'(b_col) * DIR_W'(QD) + DIR_W'(fq_c));
    sum_r = DIR_W'(DIR_W'(b_row) * DIR_W'(QD) + DIR_W'(fq_r));
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_face <= b_face;
      c_u    <= signed'(sum_c) - ONE_D;
      c_v    <= signed'(sum_r) - ONE_D;
      c_dst  <= b_dst;
    end
  end

  // longitude cordic chain, index 0 is the quadrant prep register
  logic                 t_vld  [CORDIC_STEPS+1];
  logic signed [CW-1:0] t_x    [CORDIC_STEPS+1];
  logic signed [CW-1:0] t_y    [CORDIC_STEPS+1];
  logic signed [AW-1:0] t_a    [CORDIC_STEPS+1];
  logic                 t_zero [CORDIC_STEPS+1];
  logic signed [AW-1:0] t_base [CORDIC_STEPS+1];
  logic signed [CW-1:0] t_lat  [CORDIC_STEPS+1];
  logic [DOFF_W-1:0]    t_dst  [CORDIC_STEPS+1];

  // face basis: direction = forward + u*right + v*up
  logic signed [CW-1:0] dx, dy, dz, px, py;
  logic signed [AW-1:0] pbase;
  logic                 pzero;

  always_comb begin
    case (c_face)
      3'd0: begin
        dx = CW'(ONE_D); dy = -CW'(c_v); dz = -CW'(c_u);
      end
      3'd1: begin
        dx = -CW'(ONE_D); dy = -CW'(c_v); dz = CW'(c_u);
      end
      3'd2: begin
        dx = CW'(c_u); dy = CW'(ONE_D); dz = CW'(c_v);
      end
      3'd3: begin
        dx = CW'(c_u); dy = -CW'(ONE_D); dz = -CW'(c_v);
      end
      3'd4: begin
        dx = CW'(c_u); dy = -CW'(c_v); dz = CW'(ONE_D);
      end
      default: begin
        dx = -CW'(c_u); dy = -CW'(c_v); dz = -CW'(ONE_D);
      end
    endcase
    // rotate into the right half plane before vectoring
    pzero = (dx == '0) && (dz == '0);
    if (dx[CW-1]) begin
      if (!dz[CW-1]) begin
        pbase = QUARTER; px = dz; py = -dx;
      end else begin
        pbase = -QUARTER; px = -dz; py = dx;
      end
    end else begin
      pbase = '0; px = dx; py = dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) t_vld[0] <= 1'b0;
    else if (en) t_vld[0] <= c_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_x[0]    <= px;
      t_y[0]    <= py;
      t_a[0]    <= '0;
      t_zero[0] <= pzero;
      t_base[0] <= pbase;
      t_lat[0]  <= dy;
      t_dst[0]  <= c_dst;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_theta
    always_ff @(posedge clk) begin
      if (rst) t_vld[i+1] <= 1'b0;
      else if (en) t_vld[i+1] <= t_vld[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!t_y[i][CW-1]) begin
          t_x[i+1] <= t_x[i] + (t_y[i] >>> i);
          t_y[i+1] <= t_y[i] - (t_x[i] >>> i);
          t_a[i+1] <= t_a[i] + ATAN_TAB[i];
        end else begin
          t_x[i+1] <= t_x[i] - (t_y[i] >>> i);
          t_y[i+1] <= t_y[i] + (t_x[i] >>> i);
          t_a[i+1] <= t_a[i] - ATAN_TAB[i];
        end
        t_zero[i+1] <= t_zero[i];
        t_base[i+1] <= t_base[i];
        t_lat[i+1]  <= t_lat[i];
        t_dst[i+1]  <= t_dst[i];
      end
    end
  end

  // latitude cordic chain, index 0 holds gain-corrected radius and longitude
  logic                 p_vld   [CORDIC_STEPS+1];
  logic signed [CW-1:0] p_x     [CORDIC_STEPS+1];
  logic signed [CW-1:0] p_y     [CORDIC_STEPS+1];
  logic signed [AW-1:0] p_a     [CORDIC_STEPS+1];
  logic signed [AW-1:0] p_theta [CORDIC_STEPS+1];
  logic [DOFF_W-1:0]    p_dst   [CORDIC_STEPS+1];
  logic [CW+15:0]       rad_prod;

  assign rad_prod = (CW + 16)'(t_x[CORDIC_STEPS]) * (CW + 16)'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (rst) p_vld[0] <= 1'b0;
    else if (en) p_vld[0] <= t_vld[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x[0]     <= signed'(rad_prod[CW+15:16]);
      p_y[0]     <= t_lat[CORDIC_STEPS];
      p_a[0]     <= '0;
      p_theta[0] <= t_zero[CORDIC_STEPS] ? '0
                  : t_base[CORDIC_STEPS] + t_a[CORDIC_STEPS];
      p_dst[0]   <= t_dst[CORDIC_STEPS];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_phi
    always_ff @(posedge clk) begin
      if (rst) p_vld[i+1] <= 1'b0;
      else if (en) p_vld[i+1] <= p_vld[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!p_y[i][CW-1]) begin
          p_x[i+1] <= p_x[i] + (p_y[i] >>> i);
          p_y[i+1] <= p_y[i] - (p_x[i] >>> i);
          p_a[i+1] <= p_a[i] + ATAN_TAB[i];
        end else begin
          p_x[i+1] <= p_x[i] - (p_y[i] >>> i);
          p_y[i+1] <= p_y[i] + (p_x[i] >>> i);
          p_a[i+1] <= p_a[i] - ATAN_TAB[i];
        end
        p_theta[i+1] <= p_theta[i];
        p_dst[i+1]   <= p_dst[i];
      end
    end
  end

  // stage e: angles to image coordinates
  logic                e_vld;
  logic [SCOORD_W-1:0] e_scol;
  logic [DIM_W-1:0]    e_srow;
  logic [DOFF_W-1:0]   e_dst;
  logic [ANG_BITS-1:0] uq;
  logic signed [AW+1:0] vq_full;
  logic [ANG_BITS:0]   vq;
  logic [ANG_BITS+DIM_W-1:0] col_prod;
  logic [ANG_BITS+DIM_W:0]   row_prod;

  always_comb begin
    uq = ANG_BITS'(p_theta[CORDIC_STEPS] + HALF);
    vq_full = (AW + 2)'(HALF) - ((AW + 2)'(p_a[CORDIC_STEPS]) <<< 1);
    if (vq_full[AW+1]) vq = '0;
    else if (vq_full > (AW + 2)'(2 ** ANG_BITS)) vq = (ANG_BITS + 1)'(2 ** ANG_BITS);
    else vq = vq_full[ANG_BITS:0];
    col_prod = (ANG_BITS + DIM_W)'(uq) * (ANG_BITS + DIM_W)'(w_eff);
    row_prod = (ANG_BITS + DIM_W + 1)'(vq) * (ANG_BITS + DIM_W + 1)'(h_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (en) e_vld <= p_vld[CORDIC_STEPS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_scol <= col_prod[ANG_BITS+SCOORD_W-1:ANG_BITS];
      e_srow <= row_prod[ANG_BITS+DIM_W-1:ANG_BITS];
      e_dst  <= p_dst[CORDIC_STEPS];
    end
  end

  // stage f: bottom edge row wraps to zero
  logic                f_vld;
  logic [SCOORD_W-1:0] f_scol, f_srow;
  logic [DOFF_W-1:0]   f_dst;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_scol <= e_scol;
      f_srow <= (e_srow >= h_eff) ? SCOORD_W'(e_srow - h_eff) : SCOORD_W'(e_srow);
      f_dst  <= e_dst;
    end
  end

  // stage g: linear pixel index
  logic                g_vld;
  logic [SCOORD_W-1:0] g_scol, g_srow;
  logic [SOFF_W-1:0]   g_lin;
  logic [DOFF_W-1:0]   g_dst;

  always_ff @(posedge clk) begin
    if (rst) g_vld <= 1'b0;
    else if (en) g_vld <= f_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_scol <= f_scol;
      g_srow <= f_srow;
      g_lin  <= SOFF_W'(f_srow) * SOFF_W'(w_eff) + SOFF_W'(f_scol);
      g_dst  <= f_dst;
    end
  end

  // output register: scale by channel count
  logic [SCOORD_W-1:0] o_scol, o_srow;
  logic [SOFF_W-1:0]   o_soff;
  logic [DOFF_W-1:0]   o_dst;

  always_ff @(posedge clk) begin
    if (rst) o_vld <= 1'b0;
    else if (en) o_vld <= g_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_scol <= g_scol;
      o_srow <= g_srow;
      o_soff <= SOFF_W'(g_lin * SOFF_W'(ch_eff));
      o_dst  <= g_dst;
    end
  end

  assign out_ch.valid      = o_vld;
  assign out_ch.src_col    = o_scol;
  assign out_ch.src_row    = o_srow;
  assign out_ch.src_offset = o_soff;
  assign out_ch.dst_offset = o_dst;

  // checks
  `include "equirect_to_cubemap_address_top_assert.svh"

  `E2C_ASSERT_NOW(a_col_range, clk, rst, o_vld, DIM_W'(o_scol) < w_eff, "src_col not below width")
  `E2C_ASSERT_NOW(a_row_range, clk, rst, o_vld, DIM_W'(o_srow) < h_eff, "src_row not below height")
  `E2C_ASSERT_NOW(a_rad_pos, clk, rst, p_vld[0], !p_x[0][CW-1], "latitude radius negative")
  `E2C_ASSERT_NEXT(a_hold, clk, rst, o_vld && !out_ch.ready, o_vld && $stable(o_soff), "stalled result lost")

endmodule
